FILE: rtl/core/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg
// shared types, character codes and register map for the quoted token splitter
// ----------------------------------------------------------------------------
package qts_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    // register indexes, taken from paddr[2]
    typedef enum logic {
        REG_SWITCH_CHAR = 1'b0,
        REG_TOKEN_LIMIT = 1'b1
    } t_reg_idx;

    localparam logic [CHAR_W-1:0]  SWITCH_CHAR_RST = 8'd47;
    localparam logic [COUNT_W-1:0] TOKEN_LIMIT_RST = 10'd255;

    typedef struct packed {
        logic [CHAR_W-1:0]  switch_char;
        logic [COUNT_W-1:0] token_limit;
    } t_cfg;

    typedef struct packed {
        logic               in_token;
        logic               quoting_on;
        logic               quote_just_closed;
        logic [COUNT_W-1:0] emitted_count;
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              starts_token;
        logic              line_end;
    } t_result;

    localparam t_state STATE_IDLE = '{
        in_token:          1'b0,
        quoting_on:        1'b0,
        quote_just_closed: 1'b0,
        emitted_count:     '0
    };

endpackage

FILE: rtl/core/qts_cfg.sv
// ----------------------------------------------------------------------------
// qts_cfg
// apb register file holding switch character and token length limit
// ----------------------------------------------------------------------------
module qts_cfg import qts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.switch_char <= SWITCH_CHAR_RST;
            r_cfg.token_limit <= TOKEN_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SWITCH_CHAR: r_cfg.switch_char <= pwdata[CHAR_W-1:0];
                REG_TOKEN_LIMIT: r_cfg.token_limit <= pwdata[COUNT_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_SWITCH_CHAR: prdata[CHAR_W-1:0]  = r_cfg.switch_char;
            REG_TOKEN_LIMIT: prdata[COUNT_W-1:0] = r_cfg.token_limit;
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/qts_step.sv
// ----------------------------------------------------------------------------
// qts_step
// per-character decision: next tokenizer state and the result for one char
// ----------------------------------------------------------------------------
module qts_step import qts_pkg::*; (
    input  t_state            i_state,
    input  t_cfg              i_cfg,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    output t_state            o_state,
    output t_result           o_result,
    output logic              o_has_result
);

    logic               w_blank;
    logic               w_delim;
    logic [COUNT_W-1:0] w_lim;

    assign w_blank = (i_char == CH_BLANK) || (i_char == CH_TAB);
    assign w_delim = w_blank || (i_char == i_cfg.switch_char) ||
                     (i_char == CH_BANG) || (i_char == CH_EQUAL);
    // a zero limit behaves as one
    assign w_lim   = (i_cfg.token_limit == '0) ? COUNT_W'(1) : i_cfg.token_limit;

    always_comb begin
        t_state s;
        logic   absorb;
        logic   emit;
        logic   start;

        s      = i_state;
        absorb = 1'b0;
        emit   = 1'b0;
        start  = 1'b0;

        // unquoted delimiter closes the open token
        if (s.in_token && !s.quoting_on && w_delim) begin
            s = STATE_IDLE;
        end

        if (!s.in_token) begin
            if (!w_blank) begin
                s          = STATE_IDLE;
                s.in_token = 1'b1;
                start      = 1'b1;
                absorb     = 1'b1;
            end
        end else begin
            absorb = 1'b1;
        end

        if (absorb) begin
            if (i_char == CH_QUOTE) begin
                if (s.quoting_on) begin
                    s.quoting_on        = 1'b0;
                    s.quote_just_closed = 1'b1;
                end else if (s.quote_just_closed) begin
                    // doubled quote gives one literal quote
                    emit                = 1'b1;
                    s.quoting_on        = 1'b1;
                    s.quote_just_closed = 1'b0;
                end else begin
                    s.quoting_on = 1'b1;
                end
            end else begin
                emit                = 1'b1;
                s.quote_just_closed = 1'b0;
            end
            if (emit) begin
                s.emitted_count = s.emitted_count + COUNT_W'(1);
            end
            if (s.emitted_count >= w_lim) begin
                s = STATE_IDLE;
            end
        end

        if (i_last) begin
            s = STATE_IDLE;
        end

        o_state               = s;
        o_result.out_char     = emit ? i_char : '0;
        o_result.char_valid   = emit;
        o_result.starts_token = start;
        o_result.line_end     = i_last;
        o_has_result          = emit || start || i_last;
    end

endmodule

FILE: rtl/core/quoted_token_splitter_top.sv
// ----------------------------------------------------------------------------
// quoted_token_splitter_top
// command-line tokenizer with double-quote handling, one character per cycle
// ----------------------------------------------------------------------------
// latency: a result is registered, and appears in the cycle after its character transfer
// throughput: one character per cycle while the input is not stalled; the tokenizer state register is
//   updated in the same cycle the character is taken
// the result register decouples the sides: a new character is taken while
//   a result waits, unless that result is stalled
// reset: synchronous active low; state returns to between tokens, registers
//   return to switch char '/' and token limit 255, no result pending
// ----------------------------------------------------------------------------
module quoted_token_splitter_top import qts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // character input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic              i_line_last,
    // result output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_char_valid,
    output logic              o_starts_token,
    output logic              o_line_end,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result w_result;
    logic    r_out_valid;
    logic    w_has_result;
    logic    w_in_xfer;

    qts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qts_step u_step (
        .i_state      (r_state),
        .i_cfg        (w_cfg),
        .i_char       (i_char_in),
        .i_last       (i_line_last),
        .o_state      (n_state),
        .o_result     (w_result),
        .o_has_result (w_has_result)
    );

    // input is held back only while a pending result is itself stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // tokenizer state advances on every character transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_IDLE;
        end else if (w_in_xfer) begin
            r_state <= n_state;
        end
    end

    // result register: filled by a transfer that yields a result,
    // emptied once the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= w_has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_has_result) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_result.out_char;
    assign o_char_valid   = r_result.char_valid;
    assign o_starts_token = r_result.starts_token;
    assign o_line_end     = r_result.line_end;

    // a pending result always carries at least one flag
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_char_valid || o_starts_token || o_line_end))
        else $error("result without any flag set");

    // a result with char valid low shows its character as zero
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_char_valid) |-> (o_out_char == '0))
        else $error("out char not zero while char valid is low");

    // end of line always leaves the splitter between tokens with quoting off
    a_line_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_line_last) |=>
            (!r_state.in_token && !r_state.quoting_on && o_out_valid && o_line_end))
        else $error("line end did not close the token");

    // no open token means no count and no quote flags
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.in_token |->
            (r_state.emitted_count == '0 && !r_state.quoting_on &&
             !r_state.quote_just_closed))
        else $error("state flags left set between tokens");

endmodule
